[src/irp_pkg.sv]
// Package for the infrared raw-code pulse player.
// Holds the item op codes, configuration register indexes, field widths and the result type.
// No dependencies.
package irp_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned DUR_W    = 20;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // Item op codes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_TRIG  = 2'd1;
  localparam op_t OP_WRITE = 2'd2;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CARRIER_PERIOD = 1'd0;
  localparam cfg_idx_t CFG_CODE_LENGTH    = 1'd1;

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd25;
  localparam logic [LEN_W-1:0]    LENGTH_RST = 9'd1;

  // One result item
  typedef struct packed {
    logic ir_out;
    logic envelope;
    logic busy_res;
    logic done_res;
  } irp_res_t;

endpackage

[src/irp_if.sv]
// Handshake channels of the infrared raw-code pulse player.
// Input channel carries op, entry_index and entry_duration; result channel carries flags.
// Depends on irp_pkg.
interface irp_in_if;
  logic                          valid;
  logic                          ready;
  logic [irp_pkg::OP_W-1:0]      op;
  logic [irp_pkg::IDX_W-1:0]     entry_index;
  logic [irp_pkg::DUR_W-1:0]     entry_duration;

  modport source (output valid, output op, output entry_index, output entry_duration,
                  input ready);
  modport sink   (input valid, input op, input entry_index, input entry_duration,
                  output ready);
endinterface

interface irp_out_if;
  logic valid;
  logic ready;
  logic ir_out;
  logic envelope;
  logic busy_res;
  logic done_res;

  modport source (output valid, output ir_out, output envelope, output busy_res,
                  output done_res, input ready);
  modport sink   (input valid, input ir_out, input envelope, input busy_res,
                  input done_res, output ready);
endinterface

[src/irp_out_skid.sv]
// Two-entry output buffer for result items: output register plus skid register.
// Keeps the input side ready while one finished item waits at the output.
// Depends on irp_pkg.
module irp_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  irp_pkg::irp_res_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output irp_pkg::irp_res_t out_data
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  irp_pkg::irp_res_t main_r, main_nxt;
  irp_pkg::irp_res_t skid_r, skid_nxt;
  logic              pop;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign pop       = main_v_r && out_ready;

  // Steer incoming item to the output or skid register
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r) begin
      if (push) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt   = push_data;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  // Hold valid flags under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[src/ir_raw_code_pulse_player.sv]
// Top level of the infrared raw-code pulse player.
// Depends on irp_pkg, irp_if (irp_in_if, irp_out_if) and irp_out_skid.
//
// Usage:
//   in_if carries one item per handshake: a microsecond tick, a playback
//   trigger, or a write of one duration into the code table. Each accepted
//   item yields exactly one result item on out_if with ir_out, envelope,
//   busy_res and done_res as they stand after that item.
//   cfg_we/cfg_index/cfg_data write carrier_period (index 0) and
//   code_length (index 1); write only while the block is idle.
// Throughput and the code table:
//   One item per cycle sustained while the output buffer has room.
//   Results are registered there. The single-port-read code table RAM
//   has a registered read; an entry fetched by one item is forwarded
//   from the RAM output to the next tick, so no item waits.
// Reset:
//   rst_n (synchronous, active low) stops playback, clears the envelope,
//   carrier phase and tick counter, and restores carrier_period 25 and
//   code_length 1. Table contents are not cleared and stay undefined
//   until written.
// Stall:
//   A two-entry output buffer holds results; in_if.ready drops only when
//   both entries are full, i.e. after two results went untaken.
module ir_raw_code_pulse_player #(
  parameter int unsigned MAX_CODE_ENTRIES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  irp_in_if.sink                         in_if,
  irp_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [irp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irp_pkg::CFG_W-1:0]      cfg_data
);

  localparam int unsigned AW  = (MAX_CODE_ENTRIES > 1) ? $clog2(MAX_CODE_ENTRIES) : 1;
  localparam int unsigned NW  = $clog2(MAX_CODE_ENTRIES + 1);
  localparam int unsigned LW  = (NW > irp_pkg::LEN_W) ? NW : irp_pkg::LEN_W;
  localparam int unsigned DW  = irp_pkg::DUR_W;
  localparam int unsigned PW  = irp_pkg::PERIOD_W;

  // Configuration registers
  logic [PW-1:0]             period_r;
  logic [irp_pkg::LEN_W-1:0] length_r;

  // Playback state
  logic [NW-1:0] next_entry_r, next_entry_nxt;
  logic [DW-1:0] remaining_r, remaining_nxt;
  logic          pend_r, pend_nxt;
  logic          env_r, env_nxt;
  logic [PW-1:0] phase_r, phase_nxt;

  // Code table
  logic [DW-1:0] code_mem [MAX_CODE_ENTRIES];
  logic [DW-1:0] rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic              accept;
  logic              can_push;
  logic              done;
  logic [PW-1:0]     eff_period;
  logic [LW-1:0]     eff_length;
  logic [DW-1:0]     rem_eff;
  logic [PW:0]       phase_inc;
  logic [PW:0]       phase_dbl;
  irp_pkg::irp_res_t res;
  irp_pkg::irp_res_t out_data;

  assign accept      = in_if.valid && can_push;
  assign in_if.ready = can_push;

  // Apply configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= irp_pkg::PERIOD_RST;
      length_r <= irp_pkg::LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irp_pkg::CFG_CARRIER_PERIOD: period_r <= cfg_data[PW-1:0];
        irp_pkg::CFG_CODE_LENGTH:    length_r <= cfg_data[irp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp period and length to their usable ranges
  always_comb begin
    eff_period = (period_r == '0) ? PW'(1) : period_r;
    if (length_r == '0) begin
      eff_length = LW'(1);
    end else if (LW'(length_r) > LW'(MAX_CODE_ENTRIES)) begin
      eff_length = LW'(MAX_CODE_ENTRIES);
    end else begin
      eff_length = LW'(length_r);
    end
  end

  // Forward a freshly fetched duration; zero counts as one tick
  always_comb begin
    if (pend_r) begin
      rem_eff = (rd_q == '0) ? DW'(1) : rd_q;
    end else begin
      rem_eff = remaining_r;
    end
  end

  assign phase_inc = {1'b0, phase_r} + (PW+1)'(1);

  // Advance playback for the accepted item
  always_comb begin
    next_entry_nxt = next_entry_r;
    remaining_nxt  = rem_eff;
    pend_nxt       = 1'b0;
    env_nxt        = env_r;
    phase_nxt      = phase_r;
    done           = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = AW'(next_entry_r);
    wr_en          = 1'b0;
    wr_addr        = AW'(in_if.entry_index);
    if (accept) begin
      case (in_if.op)
        irp_pkg::OP_TICK: begin
          phase_nxt = (phase_inc >= {1'b0, eff_period}) ? '0 : phase_inc[PW-1:0];
          if (next_entry_r != '0) begin
            if (rem_eff > DW'(1)) begin
              remaining_nxt = rem_eff - DW'(1);
            end else if (LW'(next_entry_r) >= eff_length) begin
              env_nxt        = 1'b0;
              next_entry_nxt = '0;
              remaining_nxt  = '0;
              done           = 1'b1;
            end else begin
              env_nxt        = !env_r;
              rd_en          = 1'b1;
              pend_nxt       = 1'b1;
              next_entry_nxt = next_entry_r + NW'(1);
            end
          end
        end
        irp_pkg::OP_TRIG: begin
          if (next_entry_r == '0) begin
            env_nxt        = 1'b1;
            rd_en          = 1'b1;
            rd_addr        = '0;
            pend_nxt       = 1'b1;
            next_entry_nxt = NW'(1);
          end
        end
        irp_pkg::OP_WRITE: begin
          wr_en = (32'(in_if.entry_index) < MAX_CODE_ENTRIES);
        end
        default: ;
      endcase
    end else begin
      pend_nxt      = pend_r;
      remaining_nxt = remaining_r;
    end
  end

  // Code table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= in_if.entry_duration;
    end
    if (rd_en) begin
      rd_q <= code_mem[rd_addr];
    end
  end

  // Update playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_entry_r <= '0;
      remaining_r  <= '0;
      pend_r       <= 1'b0;
      env_r        <= 1'b0;
      phase_r      <= '0;
    end else begin
      next_entry_r <= next_entry_nxt;
      remaining_r  <= remaining_nxt;
      pend_r       <= pend_nxt;
      env_r        <= env_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // Build the result from the state after the item
  assign phase_dbl = {phase_nxt, 1'b0};
  always_comb begin
    res.envelope = env_nxt;
    res.ir_out   = env_nxt && (phase_dbl < {1'b0, eff_period});
    res.busy_res = (next_entry_nxt != '0);
    res.done_res = done;
  end

  irp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.ir_out   = out_data.ir_out;
  assign out_if.envelope = out_data.envelope;
  assign out_if.busy_res = out_data.busy_res;
  assign out_if.done_res = out_data.done_res;

endmodule
